// File: sv/mfmec_pkg.sv
// Shared constants, codes and types for the MFM EWMA clock recovery decoder.
package mfmec_pkg;

	// Field widths
	localparam int FLUX_BITS  = 16;
	localparam int CLK_BITS   = 24;
	localparam int ALPHA_BITS = 17;
	localparam int CNT_BITS   = 9;
	localparam int RUN_BITS   = 4;
	localparam int ST_BITS    = 2;
	localparam int IDX_BITS   = 3;

	// Behavior constants
	localparam int WARMUP_ITEMS = 300;
	localparam int MAX_ZERO_RUN = 15;

	localparam logic [CLK_BITS-1:0]   ONE_CLOCK = CLK_BITS'(256);
	localparam logic [CLK_BITS-1:0]   CLK_MAX   = {CLK_BITS{1'b1}};
	localparam logic [ALPHA_BITS-1:0] ALPHA_ONE = ALPHA_BITS'(65536);
	localparam logic [CNT_BITS-1:0]   CNT_MAX   = {CNT_BITS{1'b1}};

	// Shared divider sizing: numerator up to (d << 10) + clock, divisor up to 2 * clock
	localparam int DIV_NW = FLUX_BITS + 11;
	localparam int DIV_DW = CLK_BITS + 1;
	localparam int DIV_CW = $clog2(DIV_NW);

	// Quotient limits used by clamping and saturation, in (run + 1) terms
	localparam logic [DIV_DW-1:0] CLAMP_LO_Q = DIV_DW'(2);
	localparam logic [DIV_DW-1:0] CLAMP_HI_Q = DIV_DW'(4);
	localparam logic [DIV_DW-1:0] SAT_Q      = DIV_DW'(MAX_ZERO_RUN + 1);

	// Multiply-accumulate width for the EWMA
	localparam int PROD_BITS = ALPHA_BITS + CLK_BITS;
	localparam int ACC_BITS  = PROD_BITS + 1;
	localparam int EWMA_SHIFT = 16;
	localparam logic [ACC_BITS-1:0] EWMA_HALF = ACC_BITS'(32768);

	// Register indexes
	localparam logic [IDX_BITS-1:0] REG_ALPHA_GAIN    = IDX_BITS'(0);
	localparam logic [IDX_BITS-1:0] REG_INITIAL_CLOCK = IDX_BITS'(1);
	localparam logic [IDX_BITS-1:0] REG_USE_PRIOR     = IDX_BITS'(2);
	localparam logic [IDX_BITS-1:0] REG_IGNORE_LOWER  = IDX_BITS'(3);
	localparam logic [IDX_BITS-1:0] REG_CLAMP_ENABLE  = IDX_BITS'(4);

	// Status codes
	localparam logic [ST_BITS-1:0] ST_OK  = ST_BITS'(0);
	localparam logic [ST_BITS-1:0] ST_SAT = ST_BITS'(1);
	localparam logic [ST_BITS-1:0] ST_NEG = ST_BITS'(2);

	// Divider launch request
	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
	} div_req_t;

endpackage

// File: sv/mfmec_if.sv
// Valid/ready channel interfaces for flux input beats and decoded bit beats.
interface flux_in_if;
	logic                            valid;
	logic                            ready;
	logic [mfmec_pkg::FLUX_BITS-1:0] flux_interval;
	logic                            run_start;

	modport source (output valid, output flux_interval, output run_start, input ready);
	modport sink (input valid, input flux_interval, input run_start, output ready);
endinterface

interface bit_out_if;
	logic                           valid;
	logic                           ready;
	logic                           data_bit;
	logic                           last_of_item;
	logic [mfmec_pkg::CLK_BITS-1:0] clock_used;
	logic [mfmec_pkg::ST_BITS-1:0]  status;

	modport source (output valid, output data_bit, output last_of_item, output clock_used,
		output status, input ready);
	modport sink (input valid, input data_bit, input last_of_item, input clock_used,
		input status, output ready);
endinterface

// File: sv/mfmec_div.sv
// Shared radix-2 restoring divider, one quotient bit per cycle.
module mfmec_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  mfmec_pkg::div_req_t                  req,
	output logic                                 busy,
	output logic                                 done,
	output logic [mfmec_pkg::DIV_NW-1:0]         quot
);

	logic                            busy_q;
	logic                            done_q;
	logic [mfmec_pkg::DIV_CW-1:0]    cnt_q;
	logic [mfmec_pkg::DIV_DW-1:0]    rem_q;
	logic [mfmec_pkg::DIV_DW-1:0]    den_q;
	logic [mfmec_pkg::DIV_NW-1:0]    quo_q;

	logic [mfmec_pkg::DIV_DW:0]      trial;
	logic [mfmec_pkg::DIV_DW:0]      diff;
	logic                            ge;

	// Trial subtract of the shifted partial remainder
	always_comb begin
		trial = {rem_q, quo_q[mfmec_pkg::DIV_NW-1]};
		diff  = trial - {1'b0, den_q};
		ge    = trial >= {1'b0, den_q};
	end

	// Control: count iterations, pulse done after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == mfmec_pkg::DIV_CW'(mfmec_pkg::DIV_NW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath: numerator shifts out as quotient bits shift in
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[mfmec_pkg::DIV_DW-1:0] : trial[mfmec_pkg::DIV_DW-1:0];
			quo_q <= {quo_q[mfmec_pkg::DIV_NW-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = quo_q;

endmodule

// File: sv/mfm_ewma_clock_recovery_decoder.sv
// MFM flux data separator with an EWMA clock estimate: sequencer, EWMA MAC and bit emitter.
//
//  Channel   Dir  Handshake          Beat contents
//  flux_in   in   valid/ready        flux_interval[15:0], run_start
//  bit_out   out  valid/ready        data_bit, last_of_item, clock_used[23:0], status[1:0]
//  cfg       in   cfg_we, no wait    cfg_index[2:0], cfg_data[23:0]
//
// ready drops at acceptance and returns once the sequencer has emitted the item's result
// beats. A skipped interval goes from the run divide straight to emission; an unclamped run
// below one adds the EWMA multiply steps; otherwise the 27-step shared divider is used once
// for the run and once for the per-interval clock before the multiply steps and emission.
// ready is high only while the sequencer is idle; a held result beat stalls emission and,
// while beats of the item remain, acceptance of the next item. Reset restores register defaults and the clock.
module mfm_ewma_clock_recovery_decoder (
	input  logic                              clk,
	input  logic                              arst_n,
	flux_in_if.sink                           flux_in,
	bit_out_if.source                         bit_out,
	input  logic                              cfg_we,
	input  logic [mfmec_pkg::IDX_BITS-1:0]    cfg_index,
	input  logic [mfmec_pkg::CLK_BITS-1:0]    cfg_data
);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_DIV1  = 9'b000000010,
		S_WAIT1 = 9'b000000100,
		S_DIV2  = 9'b000001000,
		S_WAIT2 = 9'b000010000,
		S_MUL1  = 9'b000100000,
		S_MUL2  = 9'b001000000,
		S_MUL3  = 9'b010000000,
		S_EMIT  = 9'b100000000
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [mfmec_pkg::ALPHA_BITS-1:0] alpha_q;
	logic [mfmec_pkg::CLK_BITS-1:0]   init_clk_q;
	logic                             use_prior_q;
	logic                             ignore_lower_q;
	logic                             clamp_q;

	// Decoder state and per-item working registers
	logic [mfmec_pkg::CLK_BITS-1:0]   mean_q;
	logic [mfmec_pkg::CNT_BITS-1:0]   items_q;
	logic [mfmec_pkg::FLUX_BITS-1:0]  flux_q;
	logic                             warm_q;
	logic                             lead_pend_q;
	logic [mfmec_pkg::CLK_BITS-1:0]   lead_clk_q;
	logic [mfmec_pkg::DIV_DW-1:0]     qe_q;
	logic [mfmec_pkg::CLK_BITS-1:0]   newc_q;
	logic [mfmec_pkg::RUN_BITS-1:0]   zcnt_q;
	logic [mfmec_pkg::ST_BITS-1:0]    st_q;
	logic                             one_pend_q;
	logic [mfmec_pkg::ACC_BITS-1:0]   acc_q;

	// Output register
	logic                             out_valid_q;
	logic                             out_bit_q;
	logic                             out_last_q;
	logic [mfmec_pkg::CLK_BITS-1:0]   out_clk_q;
	logic [mfmec_pkg::ST_BITS-1:0]    out_st_q;

	// Divider hookup
	mfmec_pkg::div_req_t              div_req;
	logic                             div_busy;
	logic                             div_done;
	logic [mfmec_pkg::DIV_NW-1:0]     div_quot;

	logic                             in_fire;
	logic [mfmec_pkg::CLK_BITS-1:0]   restart_clk;
	logic [mfmec_pkg::CNT_BITS-1:0]   idx;
	logic [mfmec_pkg::CLK_BITS-1:0]   c_div;
	logic [mfmec_pkg::DIV_DW-1:0]     q_raw;
	logic [mfmec_pkg::DIV_DW-1:0]     qe;
	logic                             skip;
	logic [mfmec_pkg::RUN_BITS-1:0]   zrun;
	logic [mfmec_pkg::ST_BITS-1:0]    zst;
	logic [mfmec_pkg::CLK_BITS-1:0]   newc_sat;
	logic [mfmec_pkg::ALPHA_BITS-1:0] alpha_eff;
	logic [mfmec_pkg::ALPHA_BITS-1:0] mul_a;
	logic [mfmec_pkg::CLK_BITS-1:0]   mul_b;
	logic [mfmec_pkg::PROD_BITS-1:0]  mul_p;
	logic [mfmec_pkg::ACC_BITS-1:0]   acc_round;
	logic                             out_free;
	logic                             emit_load;

	assign in_fire       = flux_in.valid && flux_in.ready;
	assign flux_in.ready = (state_q == S_IDLE);
	assign restart_clk   = use_prior_q ? init_clk_q : mfmec_pkg::ONE_CLOCK;
	assign idx           = flux_in.run_start ? '0 : items_q;
	assign out_free      = !out_valid_q || bit_out.ready;
	// A result beat is loaded this cycle
	assign emit_load     = (state_q == S_EMIT) && out_free &&
		(lead_pend_q || (zcnt_q != '0) || one_pend_q);

	// Divider operand selection: run divide, then per-interval clock divide
	always_comb begin
		c_div       = (mean_q == '0) ? mfmec_pkg::CLK_BITS'(1) : mean_q;
		div_req     = '0;
		if (state_q == S_DIV1) begin
			div_req.start = 1'b1;
			div_req.num   = mfmec_pkg::DIV_NW'({flux_q, 10'b0}) + mfmec_pkg::DIV_NW'(c_div);
			div_req.den   = {c_div, 1'b0};
		end else if (state_q == S_DIV2) begin
			div_req.start = 1'b1;
			div_req.num   = mfmec_pkg::DIV_NW'({flux_q, 9'b0}) + mfmec_pkg::DIV_NW'(qe_q >> 1);
			div_req.den   = qe_q;
		end
	end

	mfmec_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.busy   (div_busy),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Run decision: skip, clamp, saturate, status
	always_comb begin
		q_raw = div_quot[mfmec_pkg::DIV_DW-1:0];
		skip  = ignore_lower_q && (q_raw < mfmec_pkg::CLAMP_LO_Q);
		qe    = q_raw;
		if (clamp_q) begin
			if (q_raw < mfmec_pkg::CLAMP_LO_Q)
				qe = mfmec_pkg::CLAMP_LO_Q;
			else if (q_raw > mfmec_pkg::CLAMP_HI_Q)
				qe = mfmec_pkg::CLAMP_HI_Q;
		end
		if (qe == '0) begin
			zrun = '0;
			zst  = mfmec_pkg::ST_NEG;
		end else if (qe > mfmec_pkg::SAT_Q) begin
			zrun = mfmec_pkg::RUN_BITS'(mfmec_pkg::MAX_ZERO_RUN);
			zst  = mfmec_pkg::ST_SAT;
		end else begin
			zrun = mfmec_pkg::RUN_BITS'(qe - 1'b1);
			zst  = mfmec_pkg::ST_OK;
		end
		newc_sat = (div_quot > mfmec_pkg::DIV_NW'(mfmec_pkg::CLK_MAX)) ?
			mfmec_pkg::CLK_MAX : div_quot[mfmec_pkg::CLK_BITS-1:0];
	end

	// Shared EWMA multiplier
	always_comb begin
		alpha_eff = (alpha_q > mfmec_pkg::ALPHA_ONE) ? mfmec_pkg::ALPHA_ONE : alpha_q;
		if (state_q == S_MUL1) begin
			mul_a = mfmec_pkg::ALPHA_ONE - alpha_eff;
			mul_b = mean_q;
		end else begin
			mul_a = alpha_eff;
			mul_b = newc_q;
		end
		mul_p     = mfmec_pkg::PROD_BITS'(mul_a) * mfmec_pkg::PROD_BITS'(mul_b);
		acc_round = acc_q + mfmec_pkg::EWMA_HALF;
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q        <= mfmec_pkg::ALPHA_BITS'(6554);
			init_clk_q     <= mfmec_pkg::ONE_CLOCK;
			use_prior_q    <= 1'b0;
			ignore_lower_q <= 1'b0;
			clamp_q        <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				mfmec_pkg::REG_ALPHA_GAIN:    alpha_q        <= cfg_data[mfmec_pkg::ALPHA_BITS-1:0];
				mfmec_pkg::REG_INITIAL_CLOCK: init_clk_q     <= cfg_data;
				mfmec_pkg::REG_USE_PRIOR:     use_prior_q    <= cfg_data[0];
				mfmec_pkg::REG_IGNORE_LOWER:  ignore_lower_q <= cfg_data[0];
				mfmec_pkg::REG_CLAMP_ENABLE:  clamp_q        <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Sequencer, clock state and emitter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mean_q      <= mfmec_pkg::ONE_CLOCK;
			items_q     <= '0;
			lead_pend_q <= 1'b0;
			one_pend_q  <= 1'b0;
			zcnt_q      <= '0;
			warm_q      <= 1'b0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_load)
				out_valid_q <= 1'b1;
			else if (bit_out.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (flux_in.run_start)
							mean_q <= restart_clk;
						lead_pend_q <= flux_in.run_start;
						items_q     <= (idx == mfmec_pkg::CNT_MAX) ? idx : idx + 1'b1;
						warm_q      <= !use_prior_q &&
							(idx < mfmec_pkg::CNT_BITS'(mfmec_pkg::WARMUP_ITEMS));
						state_q     <= S_DIV1;
					end
				end
				S_DIV1: state_q <= S_WAIT1;
				S_WAIT1: begin
					if (div_done) begin
						zcnt_q     <= (skip || warm_q) ? '0 : zrun;
						one_pend_q <= !skip && !warm_q;
						if (skip)
							state_q <= S_EMIT;
						else if (qe >= mfmec_pkg::CLAMP_LO_Q)
							state_q <= S_DIV2;
						else
							state_q <= S_MUL1;
					end
				end
				S_DIV2: state_q <= S_WAIT2;
				S_WAIT2: begin
					if (div_done)
						state_q <= S_MUL1;
				end
				S_MUL1: begin
					acc_q   <= {1'b0, mul_p};
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					acc_q   <= acc_q + {1'b0, mul_p};
					state_q <= S_MUL3;
				end
				S_MUL3: begin
					mean_q  <= acc_round[mfmec_pkg::EWMA_SHIFT +: mfmec_pkg::CLK_BITS];
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						if (lead_pend_q) begin
							lead_pend_q <= 1'b0;
							if (!one_pend_q)
								state_q <= S_IDLE;
						end else if (zcnt_q != '0) begin
							zcnt_q      <= zcnt_q - 1'b1;
						end else if (one_pend_q) begin
							one_pend_q  <= 1'b0;
							state_q     <= S_IDLE;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Per-item payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			flux_q     <= flux_in.flux_interval;
			lead_clk_q <= restart_clk;
		end
		if (state_q == S_WAIT1 && div_done) begin
			qe_q   <= qe;
			st_q   <= zst;
			newc_q <= mean_q;
		end
		if (state_q == S_WAIT2 && div_done)
			newc_q <= newc_sat;
		if (state_q == S_EMIT && out_free) begin
			if (lead_pend_q) begin
				out_bit_q  <= 1'b1;
				out_last_q <= !one_pend_q;
				out_clk_q  <= lead_clk_q;
				out_st_q   <= mfmec_pkg::ST_OK;
			end else begin
				out_bit_q  <= (zcnt_q == '0);
				out_last_q <= (zcnt_q == '0);
				out_clk_q  <= newc_q;
				out_st_q   <= st_q;
			end
		end
	end

	assign bit_out.valid        = out_valid_q;
	assign bit_out.data_bit     = out_bit_q;
	assign bit_out.last_of_item = out_last_q;
	assign bit_out.clock_used   = out_clk_q;
	assign bit_out.status       = out_st_q;

	// The divider is never relaunched while it is still iterating
	a_div_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_busy)
		else $error("divider started while busy");

	// An accepted item holds off the next one
	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !flux_in.ready)
		else $error("input ready right after accept");

	// Zero-run counter never exceeds the saturation limit
	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		zcnt_q <= mfmec_pkg::RUN_BITS'(mfmec_pkg::MAX_ZERO_RUN))
		else $error("zero run counter out of range");

	// Emission only loads a beat while the sequencer is in its emit step
	a_emit_only: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_EMIT))
		else $error("result beat loaded outside emit");

endmodule
